[rtl/atb_pkg.sv]
// ----------------------------------------------------------------------------
// atb_pkg
// Shared types, constants and the micro-rotation angle table for the
// CORDIC vector-to-binary-angle pipeline.
// ----------------------------------------------------------------------------
package atb_pkg;

  localparam int ANGLE_BITS_DEFAULT = 16;
  localparam int COORD_BITS_DEFAULT = 16;

  // CORDIC datapath: angles are fractions of a turn, 2^64 = one full turn
  localparam int TURN_BITS    = 64;
  localparam int CORDIC_STEPS = 62;
  localparam int SHIFT_BITS   = 6;
  // the larger coordinate is normalised so its msb lands on this bit
  localparam int NORM_MSB     = 59;

  typedef logic signed [TURN_BITS-1:0] vec_t;
  typedef logic        [TURN_BITS-1:0] turn_t;

  localparam turn_t RAD_TO_TURN = 64'h28BE_60DB_9391_054A;
  localparam turn_t EIGHTH_TURN  = 64'h2000_0000_0000_0000;
  localparam turn_t QUARTER_TURN = 64'h4000_0000_0000_0000;
  localparam turn_t HALF_TURN    = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    OCT_CORDIC,
    OCT_ZERO,
    OCT_EIGHTH
  } oct_kind_t;

  // per-request side information carried alongside the datapath
  typedef struct packed {
    logic      yneg;
    logic      xneg;
    logic      swap;
    oct_kind_t kind;
  } side_t;

  // long division by a small constant, one quotient bit at a time (elaboration only)
  function automatic turn_t div_turn(input turn_t num, input int unsigned den);
    turn_t quo;
    turn_t rem;
    quo = '0;
    rem = '0;
    for (int b = TURN_BITS - 1; b >= 0; b--) begin
      rem = {rem[TURN_BITS-2:0], num[b]};
      if (rem >= turn_t'(den)) begin
        rem    = rem - turn_t'(den);
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-i) as a truncated odd-power series, in turn units (elaboration only)
  function automatic turn_t micro_angle(input int unsigned i);
    turn_t       sum;
    turn_t       term;
    int unsigned k;
    int unsigned s;
    sum = '0;
    if (i == 0) begin
      sum = EIGHTH_TURN;
    end else begin
      for (k = 0; k < 64; k++) begin
        s = i * (2 * k + 1);
        if (s < 64) begin
          term = div_turn(RAD_TO_TURN >> s, 2 * k + 1);
          if (k[0]) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
    end
    return sum;
  endfunction

endpackage

[rtl/atan2_to_binary_angle.sv]
// ----------------------------------------------------------------------------
// atan2_to_binary_angle
// Direction of a signed vector (y, x) as an unsigned binary angle, one full
// turn = 2^ANGLE_BITS, by a fully pipelined CORDIC in vectoring mode.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_stall    y_value, x_value (COORD_BITS, signed)
//  out      out_valid / out_stall  angle (ANGLE_BITS, unsigned)
//
//  One request accepted per cycle unless out_stall holds a waiting result; stages
//  A to D, one register stage per CORDIC step (62 steps of 64-bit add/sub), F1, F2.
//  Front end: magnitudes, octant select, msb search, normalising shift.
//  Reset clears only the valid bits; no state survives between requests.
//  out_stall with a waiting result freezes the whole pipeline, in_stall follows.
// ----------------------------------------------------------------------------
module atan2_to_binary_angle #(
  parameter int ANGLE_BITS = atb_pkg::ANGLE_BITS_DEFAULT,
  parameter int COORD_BITS = atb_pkg::COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] y_value,
  input  logic signed [COORD_BITS-1:0] x_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic        [ANGLE_BITS-1:0] angle
);

  localparam int N  = atb_pkg::CORDIC_STEPS;
  localparam int TB = atb_pkg::TURN_BITS;
  localparam int SB = atb_pkg::SHIFT_BITS;

  logic en;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage A: magnitudes and signs
  logic                  a_vld;
  logic [COORD_BITS-1:0] a_ymag;
  logic [COORD_BITS-1:0] a_xmag;
  logic                  a_yneg;
  logic                  a_xneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_yneg <= y_value[COORD_BITS-1];
      a_xneg <= x_value[COORD_BITS-1];
      // most negative input wraps to 2^(COORD_BITS-1), correct as unsigned
      a_ymag <= y_value[COORD_BITS-1] ? (~y_value + 1'b1) : y_value;
      a_xmag <= x_value[COORD_BITS-1] ? (~x_value + 1'b1) : x_value;
    end
  end

  // stage B: octant select
  logic                  b_vld;
  logic [COORD_BITS-1:0] b_big;
  logic [COORD_BITS-1:0] b_small;
  atb_pkg::side_t        b_side;
  atb_pkg::side_t        b_side_next;
  logic                  swap;

  assign swap = a_ymag > a_xmag;

  always_comb begin
    b_side_next.yneg = a_yneg;
    b_side_next.xneg = a_xneg;
    b_side_next.swap = swap;
    if (a_ymag == '0 || a_xmag == '0) begin
      b_side_next.kind = atb_pkg::OCT_ZERO;
    end else if (a_ymag == a_xmag) begin
      b_side_next.kind = atb_pkg::OCT_EIGHTH;
    end else begin
      b_side_next.kind = atb_pkg::OCT_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_big   <= swap ? a_ymag : a_xmag;
      b_small <= swap ? a_xmag : a_ymag;
      b_side  <= b_side_next;
    end
  end

  // stage C: msb search on the larger coordinate
  logic                  c_vld;
  logic [COORD_BITS-1:0] c_big;
  logic [COORD_BITS-1:0] c_small;
  logic [SB-1:0]         c_shift;
  atb_pkg::side_t        c_side;
  logic [SB-1:0]         msb;

  always_comb begin
    msb = '0;
    for (int j = 0; j < COORD_BITS; j++) begin
      if (b_big[j]) begin
        msb = SB'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_big   <= b_big;
      c_small <= b_small;
      c_shift <= SB'(atb_pkg::NORM_MSB) - msb;
      c_side  <= b_side;
    end
  end

  // stage D: normalising shift, feeds the CORDIC chain
  logic           cv    [0:N];
  atb_pkg::vec_t  cx    [0:N];
  atb_pkg::vec_t  cy    [0:N];
  atb_pkg::turn_t cz    [0:N];
  atb_pkg::side_t cside [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]    <= atb_pkg::vec_t'(TB'(c_big) << c_shift);
      cy[0]    <= atb_pkg::vec_t'(TB'(c_small) << c_shift);
      cz[0]    <= '0;
      cside[0] <= c_side;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    atb_cordic_stage #(
      .STEP(i)
    ) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (cv[i]),
      .in_x    (cx[i]),
      .in_y    (cy[i]),
      .in_z    (cz[i]),
      .in_side (cside[i]),
      .out_vld (cv[i+1]),
      .out_x   (cx[i+1]),
      .out_y   (cy[i+1]),
      .out_z   (cz[i+1]),
      .out_side(cside[i+1])
    );
  end

  // stage F1: special octant values, mirror about the diagonal
  logic           f_vld;
  atb_pkg::turn_t f_z;
  logic           f_yneg;
  logic           f_xneg;
  atb_pkg::turn_t oct;

  always_comb begin
    case (cside[N].kind)
      atb_pkg::OCT_CORDIC: oct = cz[N];
      atb_pkg::OCT_EIGHTH: oct = atb_pkg::EIGHTH_TURN;
      atb_pkg::OCT_ZERO:   oct = '0;
      default:             oct = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= cv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_z    <= cside[N].swap ? (atb_pkg::QUARTER_TURN - oct) : oct;
      f_yneg <= cside[N].yneg;
      f_xneg <= cside[N].xneg;
    end
  end

  // stage F2: quadrant fold, output register
  atb_pkg::turn_t full;

  always_comb begin
    if (f_xneg) begin
      full = f_yneg ? (atb_pkg::HALF_TURN + f_z) : (atb_pkg::HALF_TURN - f_z);
    end else begin
      full = f_yneg ? (TB'(0) - f_z) : f_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= full[TB-1 -: ANGLE_BITS];
    end
  end

endmodule

[rtl/atb_cordic_stage.sv]
// ----------------------------------------------------------------------------
// atb_cordic_stage
// One registered CORDIC vectoring step: rotates (x, y) towards the x axis
// and accumulates the micro-rotation angle.
// ----------------------------------------------------------------------------
module atb_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  atb_pkg::vec_t     in_x,
  input  atb_pkg::vec_t     in_y,
  input  atb_pkg::turn_t    in_z,
  input  atb_pkg::side_t    in_side,
  output logic              out_vld,
  output atb_pkg::vec_t     out_x,
  output atb_pkg::vec_t     out_y,
  output atb_pkg::turn_t    out_z,
  output atb_pkg::side_t    out_side
);

  localparam atb_pkg::turn_t STEP_ANGLE = atb_pkg::micro_angle(STEP);

  atb_pkg::vec_t  dx;
  atb_pkg::vec_t  dy;
  atb_pkg::vec_t  x_next;
  atb_pkg::vec_t  y_next;
  atb_pkg::turn_t z_next;

  assign dx = in_y >>> STEP;
  assign dy = in_x >>> STEP;

  always_comb begin
    if (!in_y[atb_pkg::TURN_BITS-1]) begin
      x_next = in_x + dx;
      y_next = in_y - dy;
      z_next = in_z + STEP_ANGLE;
    end else begin
      x_next = in_x - dx;
      y_next = in_y + dy;
      z_next = in_z - STEP_ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_side <= in_side;
    end
  end

endmodule

[rtl/atb_checker.sv]
// ----------------------------------------------------------------------------
// atb_checker
// Port-level checks on the binary-angle pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module atb_checker #(
  parameter int ANGLE_BITS = atb_pkg::ANGLE_BITS_DEFAULT
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [ANGLE_BITS-1:0] angle
);

  // input side is held back only by a blocked result
  a_stall_cause: assert property (@(posedge clk)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow a blocked result");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(angle))
    else $error("stalled result dropped or changed");

endmodule

bind atan2_to_binary_angle atb_checker #(
  .ANGLE_BITS(ANGLE_BITS)
) u_atb_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .angle    (angle)
);

[tb/atan2_to_binary_angle_tb.sv]
// ----------------------------------------------------------------------------
// atan2_to_binary_angle_tb
// Drives signed (y, x) vectors into the CORDIC angle pipeline and checks each
// binary angle against a bit-exact 64-bit vectoring model kept in the bench.
// Directed corner vectors first, then random vectors with random idle bursts
// on both channels and one long receiver hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module atan2_to_binary_angle_tb;

  localparam int ANGLE_BITS = atb_pkg::ANGLE_BITS_DEFAULT;
  localparam int COORD_BITS = atb_pkg::COORD_BITS_DEFAULT;
  localparam int QUIET_TAIL = 150;
  localparam int RANDOM_ITEMS = 800;
  localparam int HOLD_AFTER = 120;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 100000;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [ANGLE_BITS-1:0] bangle_t;

  typedef struct {
    coord_t y;
    coord_t x;
  } vec_req_t;

  typedef struct {
    coord_t  y;
    coord_t  x;
    bangle_t angle;
  } angle_exp_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    in_valid = 1'b0;
  logic    in_stall;
  coord_t  y_value = '0;
  coord_t  x_value = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  bangle_t angle;

  vec_req_t       vec_queue[$];
  angle_exp_t     angle_queue[$];
  atb_pkg::turn_t atan_step[atb_pkg::CORDIC_STEPS];

  int   total_reqs;
  int   accepted_reqs = 0;
  int   errors = 0;
  int   cycles = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic calm = 1'b0;

  atan2_to_binary_angle #(
    .ANGLE_BITS(ANGLE_BITS),
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .y_value(y_value),
    .x_value(x_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .angle(angle)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // atan(2^-i) in 2^-64 turn units, odd-power series with truncated terms
  function automatic atb_pkg::turn_t series_atan(input int unsigned i);
    atb_pkg::turn_t acc;
    atb_pkg::turn_t term;
    int unsigned    k;
    acc = '0;
    if (i == 0) begin
      acc = atb_pkg::EIGHTH_TURN;
    end else begin
      for (k = 0; i * (2 * k + 1) < 64; k++) begin
        term = (atb_pkg::RAD_TO_TURN >> (i * (2 * k + 1))) / atb_pkg::turn_t'(2 * k + 1);
        if (k[0]) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return acc;
  endfunction

  // atan(minor/major) for major >= minor >= 0, vectoring mode
  function automatic atb_pkg::turn_t octant_turns(input atb_pkg::turn_t major,
                                                  input atb_pkg::turn_t minor);
    atb_pkg::vec_t  cx;
    atb_pkg::vec_t  cy;
    atb_pkg::vec_t  sx;
    atb_pkg::vec_t  sy;
    atb_pkg::turn_t acc;
    int unsigned    sh;
    acc = '0;
    if (major == 0 || minor == 0) begin
      return '0;
    end
    if (major == minor) begin
      return atb_pkg::EIGHTH_TURN;
    end
    sh = 0;
    while (sh < 60 && (major << sh) < (atb_pkg::turn_t'(1) << atb_pkg::NORM_MSB)) begin
      sh++;
    end
    cx = atb_pkg::vec_t'(major << sh);
    cy = atb_pkg::vec_t'(minor << sh);
    for (int i = 0; i < atb_pkg::CORDIC_STEPS; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (!cy[atb_pkg::TURN_BITS-1]) begin
        cx = cx + sy;
        cy = cy - sx;
        acc = acc + atan_step[i];
      end else begin
        cx = cx - sy;
        cy = cy + sx;
        acc = acc - atan_step[i];
      end
    end
    return acc;
  endfunction

  function automatic bangle_t predict_angle(input coord_t y, input coord_t x);
    longint         yl;
    longint         xl;
    atb_pkg::turn_t ay;
    atb_pkg::turn_t ax;
    atb_pkg::turn_t dir;
    yl = y;
    xl = x;
    ay = atb_pkg::turn_t'(yl < 0 ? -yl : yl);
    ax = atb_pkg::turn_t'(xl < 0 ? -xl : xl);
    if (ay > ax) begin
      dir = atb_pkg::QUARTER_TURN - octant_turns(ay, ax);
    end else begin
      dir = octant_turns(ax, ay);
    end
    if (xl < 0) begin
      dir = (yl < 0) ? atb_pkg::HALF_TURN + dir : atb_pkg::HALF_TURN - dir;
    end else if (yl < 0) begin
      dir = '0 - dir;
    end
    return dir[atb_pkg::TURN_BITS-1 -: ANGLE_BITS];
  endfunction

  task automatic add_vec(input int y, input int x);
    vec_req_t v;
    v.y = coord_t'(y);
    v.x = coord_t'(x);
    vec_queue.push_back(v);
  endtask

  task automatic add_random_vec();
    int m;
    int d;
    int pick[6];
    pick = '{-32768, -32767, -1, 0, 1, 32767};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: add_vec($urandom_range(0, 65535), $urandom_range(0, 65535));
      4, 5: add_vec(int'($urandom_range(0, 40)) - 20, int'($urandom_range(0, 40)) - 20);
      6: begin
        m = $urandom_range(0, 32767);
        d = int'($urandom_range(0, 4)) - 2;
        add_vec($urandom_range(0, 1) ? m : -m, $urandom_range(0, 1) ? m + d : -(m + d));
      end
      7: begin
        if ($urandom_range(0, 1)) begin
          add_vec(int'($urandom_range(0, 6)) - 3, $urandom_range(0, 65535));
        end else begin
          add_vec($urandom_range(0, 65535), int'($urandom_range(0, 6)) - 3);
        end
      end
      8: add_vec($urandom_range(0, 65535), 256);
      default: add_vec(pick[$urandom_range(0, 5)], pick[$urandom_range(0, 5)]);
    endcase
  endtask

  // driver: presents requests, records the expectation on each acceptance
  always @(posedge clk) begin
    vec_req_t   nxt;
    angle_exp_t e;
    logic       nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        e.y = y_value;
        e.x = x_value;
        e.angle = predict_angle(y_value, x_value);
        angle_queue.push_back(e);
        accepted_reqs <= accepted_reqs + 1;
      end
      calm <= (vec_queue.size() < QUIET_TAIL);
      if (!in_valid || !in_stall) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 6);
        end else if (vec_queue.size() > 0) begin
          nxt = vec_queue.pop_front();
          nv = 1'b1;
          y_value <= nxt.y;
          x_value <= nxt.x;
        end
        in_valid <= nv;
      end
    end
  end

  // one long receiver hold-off so the pipeline fills and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && accepted_reqs >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks each accepted angle against the oldest expectation
  always @(posedge clk) begin
    angle_exp_t e;
    logic       ns;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (angle_queue.size() == 0) begin
          $display("%0t: unexpected angle %0d with no request outstanding", $time, angle);
          errors++;
        end else begin
          e = angle_queue.pop_front();
          if (angle !== e.angle) begin
            $display("%0t: angle for y=%0d x=%0d: expected %0d, actual %0d",
                     $time, e.y, e.x, e.angle, angle);
            errors++;
          end
        end
      end
      ns = 1'b0;
      if (hold_left > 0) begin
        ns = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        ns = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        ns = 1'b1;
      end
      out_stall <= ns;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < atb_pkg::CORDIC_STEPS; i++) begin
      atan_step[i] = series_atan(i);
    end
    // zero vector, axes, diagonals, most negative values, atan with x = one
    add_vec(0, 0);
    add_vec(0, 1);
    add_vec(0, -1);
    add_vec(1, 0);
    add_vec(-1, 0);
    add_vec(5, 5);
    add_vec(5, -5);
    add_vec(-5, 5);
    add_vec(-5, -5);
    add_vec(-32768, -32768);
    add_vec(-32768, 0);
    add_vec(0, -32768);
    add_vec(32767, -32768);
    add_vec(-32768, 32767);
    add_vec(32767, 32767);
    add_vec(1, 32767);
    add_vec(32767, 1);
    add_vec(-1, -32768);
    add_vec(-32768, 1);
    add_vec(256, 256);
    add_vec(100, 256);
    add_vec(-32768, 256);
    add_vec(32767, 32766);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_random_vec();
    end
    total_reqs = vec_queue.size();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (accepted_reqs < total_reqs || angle_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/atb_pkg.sv
rtl/atb_cordic_stage.sv
rtl/atan2_to_binary_angle.sv
rtl/atb_checker.sv
tb/atan2_to_binary_angle_tb.sv
